// ----- src/src_pkg.sv -----
// Package for the source route cache: constants, status codes, item kinds,
// front-to-back command type and the bucket hash. No dependencies.
package src_pkg;

    localparam int unsigned DefBuckets  = 32;
    localparam int unsigned DefWays     = 4;
    localparam int unsigned DefTimeBits = 32;

    localparam logic [47:0] FuncAddr   = 48'hC000_0004_0000;
    localparam logic [15:0] BcastRcf   = 16'hC220;
    localparam logic [31:0] ExpireRst  = 32'd600;
    localparam logic [47:0] BcastRst   = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] CfgExpire = 2'd0;
    localparam logic [1:0] CfgBcast  = 2'd1;

    typedef enum logic [1:0] {
        K_TX   = 2'd0,
        K_LRN  = 2'd1,
        K_TICK = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_ROUTED  = 4'd0,
        S_LOCAL   = 4'd1,
        S_MISS    = 4'd2,
        S_BCAST   = 4'd3,
        S_ADDED   = 4'd4,
        S_UPDATED = 4'd5,
        S_REFRESH = 4'd6,
        S_DROPPED = 4'd7,
        S_TICK    = 4'd8
    } t_status;

    // Classified command passed from front to back.
    typedef struct packed {
        t_kind        kind;
        logic         bcast;
        logic [47:0]  addr;
        logic         usable;
        logic [15:0]  rcf;
        logic [63:0]  seg_lo;
        logic [63:0]  seg_hi;
        logic [7:0]   ifn;
        logic [7:0]   bucket;
    } t_cmd;

    // Shift-xor hash of the address bytes, first byte most significant.
    // The full folded value is returned; the caller reduces it to a bucket.
    function automatic logic [17:0] hash_addr(input logic [47:0] a);
        logic [17:0] x;
        x = {10'd0, a[47:40]};
        x = (x << 2) ^ {10'd0, a[39:32]};
        x = (x << 2) ^ {10'd0, a[31:24]};
        x = (x << 2) ^ {10'd0, a[23:16]};
        x = (x << 2) ^ {10'd0, a[15:8]};
        x = (x << 2) ^ {10'd0, a[7:0]};
        x = x ^ (x >> 8);
        return x;
    endfunction

endpackage

// ----- src/src_ram.sv -----
// Generic RAM with one write port and one registered read port.
// No dependencies.
module src_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/src_front.sv -----
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on src_pkg.
module src_front #(
    parameter int unsigned BUCKETS = src_pkg::DefBuckets
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_kind,
    input  logic [47:0]   i_addr,
    input  logic [15:0]   i_rcf,
    input  logic [63:0]   i_seg_lo,
    input  logic [63:0]   i_seg_hi,
    input  logic [7:0]    i_ifn,
    input  logic [47:0]   i_bcast_addr,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output src_pkg::t_cmd o_cmd
);
    import src_pkg::*;
    // Bucket reduction: a mask for a power of two, otherwise a reciprocal
    // multiplication that is exact for every 18-bit hash value.
    localparam bit          BPow2      = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam int unsigned RecipShift = 26;
    localparam longint unsigned Recip  =
        ((64'd1 << RecipShift) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

    t_cmd        r_q [2];
    logic [1:0]  r_cnt, n_cnt;
    logic        r_rd, r_wr;
    t_cmd        w_cmd;
    logic [47:0] w_a;
    logic        w_push, w_pop;
    logic [17:0] w_hash, w_quot, w_rem, w_bsel;
    logic [43:0] w_prod;

    // Classification of the incoming item.
    always_comb begin
        w_a = (i_kind == K_LRN) ? {1'b0, i_addr[46:0]} : i_addr;
        w_hash = hash_addr(w_a);
        w_prod = {26'd0, w_hash} * {18'd0, 26'(Recip)};
        w_quot = 18'(w_prod >> RecipShift);
        w_rem  = w_hash - 18'(w_quot * BUCKETS);
        w_bsel = BPow2 ? (w_hash & 18'(BUCKETS - 1)) : w_rem;
        w_cmd.kind   = t_kind'(i_kind);
        w_cmd.bcast  = (i_addr == i_bcast_addr) || (i_addr == FuncAddr);
        w_cmd.addr   = w_a;
        w_cmd.usable = i_addr[47] && (i_rcf[12:8] > 5'd2);
        w_cmd.rcf    = i_rcf;
        w_cmd.seg_lo = i_seg_lo;
        w_cmd.seg_hi = i_seg_hi;
        w_cmd.ifn    = i_ifn;
        w_cmd.bucket = w_bsel[7:0];
    end

    assign o_ready = (r_cnt != 2'd2);
    // Kind 3 is swallowed without reaching the queue.
    assign w_push  = i_valid && o_ready && (i_kind != K_NONE);
    assign w_pop   = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
        end
        if (w_push) r_q[r_wr] <= w_cmd;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push) else $error("push into full queue");
    a_empty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) == !o_cmd_valid) else $error("queue valid mismatch");
endmodule

// ----- src/src_back.sv -----
// Back end: bucket read, way compare, write-back, tick sweep; output register.
// Depends on src_pkg and src_ram.
module src_back #(
    parameter int unsigned BUCKETS   = src_pkg::DefBuckets,
    parameter int unsigned WAYS      = src_pkg::DefWays,
    parameter int unsigned TIME_BITS = src_pkg::DefTimeBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  src_pkg::t_cmd i_cmd,
    input  logic [31:0]   i_expire,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [3:0]    o_status,
    output logic [15:0]   o_rcf,
    output logic [63:0]   o_route_lo,
    output logic [63:0]   o_route_hi,
    output logic          o_rii,
    output logic [4:0]    o_slack,
    output logic [7:0]    o_expired
);
    import src_pkg::*;
    localparam int unsigned ENTRIES = BUCKETS * WAYS;
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned EW = $clog2(ENTRIES);
    localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned DW = 48 + 16 + 128 + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state            r_st, n_st;
    t_cmd              r_cmd;
    logic [ENTRIES-1:0] r_valid;
    logic [WW:0]       r_way;
    logic              r_hit, r_free_f;
    logic [WW-1:0]     r_hit_w, r_free_w;
    logic [DW-1:0]     r_hd;
    logic [EW:0]       r_scan;
    logic [TIME_BITS-1:0] r_now;
    logic [7:0]        r_cnt;
    logic              r_scan_v;
    logic [3:0]        r_status;
    logic [15:0]       r_rcf;
    logic [63:0]       r_rlo, r_rhi;
    logic              r_rii, r_ovalid;
    logic [4:0]        r_slack;
    logic [3:0]        r_o_status;
    logic [15:0]       r_o_rcf;
    logic [63:0]       r_o_rlo, r_o_rhi;
    logic              r_o_rii;
    logic [4:0]        r_o_slack;
    logic [7:0]        r_o_exp;

    logic [EW-1:0]     w_raddr, w_waddr;
    logic              w_we, w_twe, w_load;
    logic [DW-1:0]     w_wd, w_rd;
    logic [TIME_BITS-1:0] w_tw, w_tr, w_exp, w_diff;
    logic [47:0]       w_addr_rd;

    // Entry data memory and last-used time memory.
    src_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wd),
        .i_raddr(w_raddr), .o_rdata(w_rd));
    src_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRIES)) u_time (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(w_waddr), .i_wdata(w_tw),
        .i_raddr(w_raddr), .o_rdata(w_tr));

    // Read address: bucket ways in order, or the sweep index.
    always_comb begin
        if (r_st == ST_SCAN) begin
            w_raddr = r_scan[EW-1:0];
        end else begin
            w_raddr = EW'(r_cmd.bucket[BW-1:0] * WAYS + r_way[WW-1:0]);
        end
    end

    assign w_addr_rd = w_rd[DW-1 -: 48];

    // Expiry compare on the sweep read.
    always_comb begin
        w_exp  = w_tr + TIME_BITS'(i_expire);
        w_diff = r_now - w_exp;
    end

    logic [EW-1:0] w_prev;
    logic [EW-1:0] w_hit_i, w_sel_i;
    logic [15:0]   w_new_rcf;
    logic          w_upd;
    assign w_prev  = EW'(r_scan - 1'b1);
    assign w_hit_i = EW'(r_cmd.bucket[BW-1:0] * WAYS + r_hit_w);
    assign w_sel_i = r_hit ? w_hit_i : EW'(r_cmd.bucket[BW-1:0] * WAYS + r_free_w);
    assign w_new_rcf = {2'b00, r_cmd.rcf[13:0]};
    assign w_upd = !r_hd[0] && (r_hd[DW-49 -: 16] != w_new_rcf) && (r_cmd.rcf[15:14] == 2'b00);

    // Write-back on the decision cycle of a transmit or learn.
    always_comb begin
        w_we    = 1'b0;
        w_twe   = 1'b0;
        w_waddr = w_sel_i;
        w_tw    = r_now;
        w_wd    = r_hd;
        if (r_st == ST_CMP && r_cmd.kind != K_TICK && !(r_cmd.kind == K_TX && r_cmd.bcast)) begin
            if (r_cmd.kind == K_TX) begin
                w_twe = r_hit;
            end else if (r_hit) begin
                w_twe = 1'b1;
                w_we  = w_upd;
                w_wd  = {r_hd[DW-1 -: 48], w_new_rcf, r_cmd.seg_lo, r_cmd.seg_hi, 1'b0};
            end else if (r_free_f) begin
                w_twe = 1'b1;
                w_we  = 1'b1;
                w_wd  = r_cmd.usable ?
                        {r_cmd.addr, w_new_rcf, r_cmd.seg_lo, r_cmd.seg_hi, 1'b0} :
                        {r_cmd.addr, 16'd0, 128'd0, 1'b1};
            end
        end
    end

    assign o_cmd_ready = (r_st == ST_IDLE);
    // The output register takes a new result once the previous one has gone.
    assign w_load = (r_st == ST_OUT) && (!r_ovalid || i_ready);

    // Sequencer: ways are read one per cycle, then the decision state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_cmd_valid) n_st = (i_cmd.kind == K_TICK) ? ST_SCAN : ST_READ;
            ST_READ: n_st = (r_cmd.kind == K_TX && r_cmd.bcast) ? ST_CMP :
                            ((r_way == (WW+1)'(WAYS)) ? ST_CMP : ST_READ);
            ST_CMP:  n_st = ST_OUT;
            ST_SCAN: n_st = (r_scan == (EW+1)'(ENTRIES)) && r_scan_v ? ST_OUT : ST_SCAN;
            ST_OUT:  if (w_load) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_valid  <= '0;
            r_now    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ovalid <= w_load || (r_ovalid && !i_ready);
            case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_way    <= '0;
                        r_hit    <= 1'b0;
                        r_free_f <= 1'b0;
                        r_scan   <= '0;
                        r_scan_v <= 1'b0;
                        r_cnt    <= '0;
                        if (i_cmd.kind == K_TICK) r_now <= r_now + 1'b1;
                    end
                end
                ST_READ: begin
                    // Data for way r_way-1 arrives now.
                    if (r_way != '0) begin
                        if (!r_hit && r_valid[EW'(r_cmd.bucket[BW-1:0] * WAYS) + EW'(r_way - 1'b1)]
                            && w_addr_rd == r_cmd.addr) begin
                            r_hit   <= 1'b1;
                            r_hit_w <= WW'(r_way - 1'b1);
                            r_hd    <= w_rd;
                        end
                        if (!r_free_f && !r_valid[EW'(r_cmd.bucket[BW-1:0] * WAYS) + EW'(r_way - 1'b1)]) begin
                            r_free_f <= 1'b1;
                            r_free_w <= WW'(r_way - 1'b1);
                        end
                    end
                    r_way <= r_way + 1'b1;
                end
                ST_CMP: begin
                    if (r_cmd.kind == K_LRN && !r_hit && r_free_f) r_valid[w_sel_i] <= 1'b1;
                end
                ST_SCAN: begin
                    if (r_scan_v && r_valid[w_prev] && !w_diff[TIME_BITS-1]) begin
                        r_valid[w_prev] <= 1'b0;
                        if (r_cnt != 8'hFF) r_cnt <= r_cnt + 1'b1;
                    end
                    r_scan_v <= 1'b1;
                    if (r_scan != (EW+1)'(ENTRIES)) r_scan <= r_scan + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result formation in the decision cycle and during a sweep.
    logic [4:0] w_len;
    assign w_len = r_hd[DW-49-3 -: 5];
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CMP) begin
            r_rcf <= '0; r_rlo <= '0; r_rhi <= '0; r_rii <= 1'b0; r_slack <= '0;
            if (r_cmd.kind == K_TX) begin
                if (r_cmd.bcast || !r_hit) begin
                    r_status <= r_cmd.bcast ? S_BCAST : S_MISS;
                    r_rcf <= BcastRcf; r_rii <= 1'b1; r_slack <= 5'd16;
                end else if (!r_hd[0] && w_len != 5'd0) begin
                    r_status <= S_ROUTED;
                    r_rcf <= (r_hd[DW-49 -: 16] ^ 16'h0080) & 16'h1FFF;
                    r_rlo <= r_hd[128:65]; r_rhi <= r_hd[64:1];
                    r_rii <= 1'b1;
                    r_slack <= (w_len > 5'd18) ? 5'd0 : 5'd18 - w_len;
                end else begin
                    r_status <= S_LOCAL; r_slack <= 5'd18;
                end
            end else if (r_hit) begin
                r_status <= w_upd ? S_UPDATED : S_REFRESH;
            end else begin
                r_status <= r_free_f ? S_ADDED : S_DROPPED;
            end
        end else if (r_st == ST_SCAN) begin
            r_status <= S_TICK;
            r_rcf <= '0; r_rlo <= '0; r_rhi <= '0; r_rii <= 1'b0; r_slack <= '0;
        end
    end

    // Output register, so that the next item can be worked on under a stall.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_rcf    <= r_rcf;
            r_o_rlo    <= r_rlo;
            r_o_rhi    <= r_rhi;
            r_o_rii    <= r_rii;
            r_o_slack  <= r_slack;
            r_o_exp    <= (r_status == S_TICK) ? r_cnt : 8'd0;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_status   = r_o_status;
    assign o_rcf      = r_o_rcf;
    assign o_route_lo = r_o_rlo;
    assign o_route_hi = r_o_rhi;
    assign o_rii      = r_o_rii;
    assign o_slack    = r_o_slack;
    assign o_expired  = r_o_exp;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid) else $error("result dropped");
    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_IDLE) && i_cmd_valid && i_cmd.kind == K_TICK |=> r_now == $past(r_now) + 1'b1)
        else $error("time not advanced");
endmodule

// ----- src/source_route_cache.sv -----
// Source route cache top level: configuration registers, front and back ends.
// Depends on src_pkg, src_front, src_back, src_ram.
//
// Usage: input transactions arrive on the s_axis group; each one of kind
// transmit, learn or tick gives exactly one result transaction on m_axis
// (kind 3 is accepted and discarded). Registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Flow: a transmit or learn passes through the queue, reads its bucket one
// way per cycle, then passes the decision state and loads the output
// register; a broadcast transmit leaves the reads at once. A tick sweeps
// every entry, one per cycle, then loads the output register. The back end
// takes a new item once the last result is in the output register; the
// entry memory's single read port sets this pace, and one item is worked
// on at a time.
// The front end queues up to two classified commands, so input is taken
// while the back end works. Reset clears all valid bits at once, the time
// count and the registers to their defaults; no clearing pass is needed.
// When the receiver holds m_axis_tready low the result stays on the port;
// the back end finishes its current item and waits, the queue fills and
// then s_axis_tready falls.
module source_route_cache #(
    parameter int unsigned BUCKETS   = src_pkg::DefBuckets,
    parameter int unsigned WAYS      = src_pkg::DefWays,
    parameter int unsigned TIME_BITS = src_pkg::DefTimeBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    // station_address, route_control, segments_low, segments_high,
    // interface_number
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[3:0], rcf_out, route_out_low, route_out_high, rii_set,
    // header_slack, expired_count, zero fill
    output logic [167:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);
    import src_pkg::*;

    logic [31:0] r_expire;
    logic [47:0] r_bcast;
    logic        w_cv, w_cr;
    t_cmd        w_cmd;
    logic [3:0]  w_st;
    logic [15:0] w_rcf;
    logic [63:0] w_lo, w_hi;
    logic        w_rii;
    logic [4:0]  w_sl;
    logic [7:0]  w_ex;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire <= ExpireRst;
            r_bcast  <= BcastRst;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgExpire[0]) r_expire <= i_cfg_data[31:0];
            else                             r_bcast  <= i_cfg_data;
        end
    end

    src_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_addr(s_axis_tdata[47:0]),
        .i_rcf(s_axis_tdata[63:48]), .i_seg_lo(s_axis_tdata[127:64]),
        .i_seg_hi(s_axis_tdata[191:128]), .i_ifn(s_axis_tdata[199:192]),
        .i_bcast_addr(r_bcast),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd));

    src_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .i_expire(r_expire),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_st), .o_rcf(w_rcf), .o_route_lo(w_lo), .o_route_hi(w_hi),
        .o_rii(w_rii), .o_slack(w_sl), .o_expired(w_ex));

    assign m_axis_tdata = {6'd0, w_ex, w_sl, w_rii, w_hi, w_lo, w_rcf, w_st};
endmodule
